@@ sv/utl_pkg.sv @@
// ----------------------------------------------------------------------------
// utl_pkg
// Shared types and constants of the UTF-8 / eight-bit byte transcoder.
// ----------------------------------------------------------------------------
package utl_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_IS_UTF8 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_IS_UTF8   = 2'd1;

	// one result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       end_of_output;
	} result_t;

	// encoding selection
	typedef struct packed {
		logic source_is_utf8;
		logic dest_is_utf8;
	} mode_t;

	// results of one input item, handed from the converter to the result buffer
	typedef struct packed {
		logic       load;   // an item leaves the converter this cycle
		logic [1:0] count;  // results it gives: 0, 1 or 2
		result_t    r0;
		result_t    r1;
	} conv_res_t;

endpackage

@@ sv/utl_if.sv @@
// ----------------------------------------------------------------------------
// utl_in_if / utl_out_if / utl_cfg_if
// Valid/ready channels of the transcoder: source bytes, result bytes and
// configuration writes.
// ----------------------------------------------------------------------------
interface utl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       string_end;

	modport source (output valid, in_byte, string_end, input ready);
	modport sink   (input valid, in_byte, string_end, output ready);
endinterface

interface utl_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       end_of_output;

	modport source (output valid, out_byte, run_last, end_of_output, input ready);
	modport sink   (input valid, out_byte, run_last, end_of_output, output ready);
endinterface

interface utl_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [utl_pkg::CFG_IDX_W-1:0] index;
	logic                          data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/utl_conv.sv @@
// ----------------------------------------------------------------------------
// utl_conv
// Input register, decode state and the byte conversion logic. Produces up
// to two result items per source byte.
// ----------------------------------------------------------------------------
module utl_conv (
	input  logic               clk,
	input  logic               arst_n,
	input  utl_pkg::mode_t     mode,
	input  logic               state_clr,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               string_end,
	input  logic               load_rdy,
	output utl_pkg::conv_res_t res
);
	import utl_pkg::*;

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD3_MIN   = 8'he0;
	localparam logic [7:0] LEAD4_MIN   = 8'hf0;
	localparam logic [7:0] LONE_BYTE   = 8'hff;
	localparam logic [7:0] ENC_LEAD    = 8'hc0;
	localparam logic [7:0] ENC_CONT    = 8'h80;
	localparam logic [7:0] CONT_MASK   = 8'h3f;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// only the low two bits of the gathered code reach the low output byte
	logic [1:0] pend_q;
	logic [1:0] rem_q;

	logic       fire;
	logic [1:0] rem_new;
	logic       emit;
	logic [7:0] code8;
	logic [1:0] pend_nxt;
	logic [1:0] rem_nxt;

	assign fire     = vld_s1 && load_rdy;
	assign in_ready = !vld_s1 || load_rdy;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			end_s1  <= string_end;
		end
	end

	// conversion of the registered byte
	always_comb begin
		res          = '0;
		res.load     = fire;
		rem_new      = 2'd0;
		emit         = 1'b0;
		code8        = 8'h00;
		pend_nxt     = 2'd0;
		rem_nxt      = 2'd0;
		if (mode.source_is_utf8 == mode.dest_is_utf8) begin
			res.count = 2'd1;
			res.r0    = '{out_byte: byte_s1, run_last: 1'b1, end_of_output: end_s1};
		end else if (mode.dest_is_utf8) begin
			if (byte_s1 < ASCII_LIMIT) begin
				res.count = 2'd1;
				res.r0    = '{out_byte: byte_s1, run_last: 1'b1, end_of_output: end_s1};
			end else begin
				res.count = 2'd2;
				res.r0    = '{out_byte: ENC_LEAD | {6'b0, byte_s1[7:6]},
					run_last: 1'b0, end_of_output: 1'b0};
				res.r1    = '{out_byte: ENC_CONT | (byte_s1 & CONT_MASK),
					run_last: 1'b1, end_of_output: end_s1};
			end
		end else begin
			// UTF-8 decode: class of the byte and the code's low byte
			priority if (rem_q != 2'd0) begin
				rem_new = rem_q - 2'd1;
				code8   = {pend_q, byte_s1[5:0]};
			end else if (byte_s1 < ASCII_LIMIT || byte_s1 == LONE_BYTE) begin
				rem_new = 2'd0;
				code8   = byte_s1;
			end else if (byte_s1 < LEAD3_MIN) begin
				rem_new = 2'd1;
			end else if (byte_s1 < LEAD4_MIN) begin
				rem_new = 2'd2;
			end else begin
				rem_new = 2'd3;
			end
			// truncated sequence: missing bytes are zero bits
			if (rem_new == 2'd1) begin
				code8 = {byte_s1[1:0], 6'b0};
			end else if (rem_new != 2'd0) begin
				code8 = 8'h00;
			end
			emit = (rem_new == 2'd0) || end_s1;
			if (emit) begin
				res.count = 2'd1;
				res.r0    = '{out_byte: code8, run_last: 1'b1, end_of_output: end_s1};
			end else begin
				pend_nxt = byte_s1[1:0];
				rem_nxt  = rem_new;
			end
		end
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			rem_q  <= 2'd0;
		end else if (state_clr) begin
			pend_q <= 2'd0;
			rem_q  <= 2'd0;
		end else if (fire) begin
			pend_q <= pend_nxt;
			rem_q  <= rem_nxt;
		end
	end

endmodule

@@ sv/utl_obuf.sv @@
// ----------------------------------------------------------------------------
// utl_obuf
// Two-entry result register. Takes all results of one item at once and
// hands them out one per cycle while the result port is ready.
// ----------------------------------------------------------------------------
module utl_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  utl_pkg::conv_res_t res,
	output logic               load_rdy,
	output logic               out_valid,
	input  logic               out_ready,
	output utl_pkg::result_t   out_item
);
	import utl_pkg::*;

	result_t    e0_q;
	result_t    e1_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = e0_q;
	assign pop       = out_valid && out_ready;
	assign load_rdy  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (res.load && res.count != 2'd0) begin
			cnt_q <= res.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// entries
	always_ff @(posedge clk) begin
		if (res.load && res.count != 2'd0) begin
			e0_q <= res.r0;
			e1_q <= res.r1;
		end else if (pop) begin
			e0_q <= e1_q;
		end
	end

endmodule

@@ sv/utl_latin1_transcoder_core.sv @@
// ----------------------------------------------------------------------------
// utf8_latin1_transcoder_core
// Byte-stream transcoder between eight-bit and UTF-8 text.
//
//   channel   dir   payload                                  accepted when
//   src_ch    in    in_byte, string_end                      valid && ready
//   res_ch    out   out_byte, run_last, end_of_output        valid && ready
//   cfg_ch    in    index, data                              valid && ready
//
// A byte is registered, converted, and its results are registered in the
// result buffer for res_ch. One source byte per cycle while res_ch is ready;
// an eight-bit byte >= 0x80 sent as UTF-8 gives two results, sent one by one.
// Reset clears the registers to eight-bit in/out and drops any open sequence.
// A stalled result port holds up the input as soon as a byte waits in the
// input register behind results still in the result buffer.
// ----------------------------------------------------------------------------
module utf8_latin1_transcoder_core (
	input  logic      clk,
	input  logic      arst_n,
	utl_in_if.sink    src_ch,
	utl_out_if.source res_ch,
	utl_cfg_if.sink   cfg_ch
);
	import utl_pkg::*;

	mode_t     mode_q;
	logic      cfg_wr;
	logic      state_clr;
	logic      load_rdy;
	conv_res_t res;
	result_t   out_item;

	// configuration registers
	assign cfg_ch.ready = 1'b1;
	assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
	assign state_clr    = cfg_wr &&
		(cfg_ch.index == CFG_SOURCE_IS_UTF8 || cfg_ch.index == CFG_DEST_IS_UTF8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_ch.index)
				CFG_SOURCE_IS_UTF8: mode_q.source_is_utf8 <= cfg_ch.data;
				CFG_DEST_IS_UTF8:   mode_q.dest_is_utf8   <= cfg_ch.data;
				default:            mode_q                <= mode_q;
			endcase
		end
	end

	// converter
	utl_conv u_conv (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.state_clr  (state_clr),
		.in_valid   (src_ch.valid),
		.in_ready   (src_ch.ready),
		.in_byte    (src_ch.in_byte),
		.string_end (src_ch.string_end),
		.load_rdy   (load_rdy),
		.res        (res)
	);

	// result buffer
	utl_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.load_rdy  (load_rdy),
		.out_valid (res_ch.valid),
		.out_ready (res_ch.ready),
		.out_item  (out_item)
	);

	assign res_ch.out_byte      = out_item.out_byte;
	assign res_ch.run_last      = out_item.run_last;
	assign res_ch.end_of_output = out_item.end_of_output;

`ifndef SYNTHESIS
	// the first byte of a two-byte encoding is always followed by the second
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && !res_ch.run_last |=> res_ch.valid)
		else $error("second byte of a pair missing");

	// the end of the string is always the end of an item's results
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && res_ch.end_of_output |-> res_ch.run_last)
		else $error("end_of_output without run_last");

	// an empty result buffer never holds up the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_ch.valid |-> src_ch.ready)
		else $error("input stalled with empty result buffer");
`endif

endmodule
